/* rtl/rfd_pkg.sv */
// Package with the shared codes and field widths of the ring fault diagnosis table.
`timescale 1ns / 1ps

package rfd_pkg;

  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned NODE_W    = 3;
  localparam int unsigned VERDICT_W = 2;
  localparam int unsigned VIEW_W    = 2;
  localparam int unsigned CNT_W     = 3;

  // At most eight results per event; the last is always the final one.
  localparam logic [CNT_W-1:0] SUSP_MAX = 3'd7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TEST    = 2'd0,
    ACT_FAIL    = 2'd1,
    ACT_RECOVER = 2'd2
  } action_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERD_CORRECT     = 2'd0,
    VERD_SUSPECT     = 2'd1,
    VERD_ALL_SUSPECT = 2'd2,
    VERD_NONE        = 2'd3
  } verdict_t;

  typedef enum logic [VIEW_W-1:0] {
    VIEW_CORRECT = 2'd0,
    VIEW_FAULTY  = 2'd1,
    VIEW_UNKNOWN = 2'd3
  } view_t;

endpackage

/* rtl/rfd_chan_if.sv */
// Channel interfaces for the event input and the diagnosis result output.
`timescale 1ns / 1ps

interface rfd_in_if;
  logic                         valid;
  logic                         ready;
  logic [rfd_pkg::ACTION_W-1:0] action;
  logic [rfd_pkg::NODE_W-1:0]   node;

  modport source (output valid, output action, output node, input ready);
  modport sink (input valid, input action, input node, output ready);
endinterface

interface rfd_out_if;
  logic                          valid;
  logic                          ready;
  logic [rfd_pkg::NODE_W-1:0]    tester;
  logic [rfd_pkg::NODE_W-1:0]    tested;
  logic [rfd_pkg::VERDICT_W-1:0] verdict;
  logic                          last;

  modport source (output valid, output tester, output tested, output verdict, output last,
                  input ready);
  modport sink (input valid, input tester, input tested, input verdict, input last,
                output ready);
endinterface

/* rtl/rfd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module rfd_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ring_fault_diagnosis_table.sv */
// Top level of the ring fault diagnosis table: event sequencer around the flag and view RAMs.
`timescale 1ns / 1ps

// The block keeps a failed flag for every ring node in one RAM and each node's view of all
// nodes (unknown, correct, faulty) in a second RAM of NUM_PROCS*NUM_PROCS entries. After reset
// a clearing pass over all NUM_PROCS*NUM_PROCS view entries initialises both RAMs, during
// which no event is accepted. A fault, recovery or ignored event gives one result, which the
// final state loads into the result register once the output slot is free. A test event
// reads the tester's flag and, if the tester has not failed, walks the ring one node per
// cycle, limited by the single read port of the flag RAM; its final result then passes from
// the final state into the result register. A result waiting on the output holds the walk
// or the final step. One new event is accepted once the previous one has issued its final
// result.
module ring_fault_diagnosis_table #(
  parameter int unsigned NUM_PROCS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  rfd_in_if.sink     in_ch,
  rfd_out_if.source  out_ch
);

  localparam int unsigned PW = $clog2(NUM_PROCS);
  localparam int unsigned VW = $clog2(NUM_PROCS * NUM_PROCS);
  localparam logic [PW-1:0] LAST_IDX = PW'(NUM_PROCS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_TEST  = 5'b00100,
    S_WALK  = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [PW-1:0]                 clr_row_r, clr_row_nxt;
  logic [PW-1:0]                 clr_col_r, clr_col_nxt;
  logic [rfd_pkg::NODE_W-1:0]    node_r, node_nxt;
  logic [PW-1:0]                 next_r, next_nxt;
  logic [rfd_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [rfd_pkg::NODE_W-1:0]    fin_tested_r, fin_tested_nxt;
  logic [rfd_pkg::VERDICT_W-1:0] fin_verdict_r, fin_verdict_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [rfd_pkg::NODE_W-1:0]    out_tester_r, out_tester_nxt;
  logic [rfd_pkg::NODE_W-1:0]    out_tested_r, out_tested_nxt;
  logic [rfd_pkg::VERDICT_W-1:0] out_verdict_r, out_verdict_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          flag_we, flag_wdata, flag_rdata;
  logic [PW-1:0]                 flag_waddr, flag_raddr;
  logic                          view_we;
  logic [VW-1:0]                 view_waddr, view_raddr;
  logic [rfd_pkg::VIEW_W-1:0]    view_wdata, view_rdata;

  logic          slot_free;
  logic          in_xfer;
  logic          node_bad;
  logic [PW-1:0] node_idx;
  logic          emit;
  logic          adv;

  function automatic logic [VW-1:0] vaddr(input logic [PW-1:0] r, input logic [PW-1:0] c);
    vaddr = VW'(r) * VW'(NUM_PROCS) + VW'(c);
  endfunction

  function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
    ring_inc = (p == LAST_IDX) ? '0 : p + PW'(1);
  endfunction

  rfd_ram #(.WIDTH(1), .DEPTH(NUM_PROCS)) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .raddr (flag_raddr),
    .rdata (flag_rdata)
  );

  rfd_ram #(.WIDTH(rfd_pkg::VIEW_W), .DEPTH(NUM_PROCS * NUM_PROCS)) u_view_ram (
    .clk   (clk),
    .we    (view_we),
    .waddr (view_waddr),
    .wdata (view_wdata),
    .raddr (view_raddr),
    .rdata (view_rdata)
  );

  assign slot_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer    = in_ch.valid && in_ch.ready;
  assign node_bad   = (int'(in_ch.node) >= int'(NUM_PROCS));
  assign node_idx   = PW'(node_r);
  assign view_raddr = vaddr(node_idx, node_idx);

  assign out_ch.valid   = out_valid_r;
  assign out_ch.tester  = out_tester_r;
  assign out_ch.tested  = out_tested_r;
  assign out_ch.verdict = out_verdict_r;
  assign out_ch.last    = out_last_r;

  always_comb begin
    state_nxt       = state_r;
    clr_row_nxt     = clr_row_r;
    clr_col_nxt     = clr_col_r;
    node_nxt        = node_r;
    next_nxt        = next_r;
    cnt_nxt         = cnt_r;
    fin_tested_nxt  = fin_tested_r;
    fin_verdict_nxt = fin_verdict_r;

    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_tester_nxt  = out_tester_r;
    out_tested_nxt  = out_tested_r;
    out_verdict_nxt = out_verdict_r;
    out_last_nxt    = out_last_r;

    flag_we    = 1'b0;
    flag_waddr = clr_col_r;
    flag_wdata = 1'b0;
    flag_raddr = next_r;
    view_we    = 1'b0;
    view_waddr = vaddr(node_idx, next_r);
    view_wdata = rfd_pkg::VIEW_CORRECT;
    emit       = 1'b0;
    adv        = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        flag_we    = (clr_row_r == '0);
        view_we    = 1'b1;
        view_waddr = vaddr(clr_row_r, clr_col_r);
        view_wdata = (clr_row_r == clr_col_r) ? rfd_pkg::VIEW_CORRECT : rfd_pkg::VIEW_UNKNOWN;
        if (clr_col_r == LAST_IDX) begin
          clr_col_nxt = '0;
          clr_row_nxt = clr_row_r + PW'(1);
          if (clr_row_r == LAST_IDX) begin
            state_nxt = S_IDLE;
          end
        end else begin
          clr_col_nxt = clr_col_r + PW'(1);
        end
      end
      S_IDLE: begin
        flag_raddr = PW'(in_ch.node);
        if (in_xfer) begin
          node_nxt        = in_ch.node;
          cnt_nxt         = '0;
          fin_tested_nxt  = in_ch.node;
          fin_verdict_nxt = rfd_pkg::VERD_NONE;
          state_nxt       = S_FIN;
          if (!node_bad) begin
            unique case (in_ch.action)
              rfd_pkg::ACT_TEST: begin
                state_nxt = S_TEST;
              end
              rfd_pkg::ACT_FAIL: begin
                flag_we    = 1'b1;
                flag_waddr = PW'(in_ch.node);
                flag_wdata = 1'b1;
              end
              rfd_pkg::ACT_RECOVER: begin
                flag_we    = 1'b1;
                flag_waddr = PW'(in_ch.node);
                flag_wdata = 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_TEST: begin
        if (flag_rdata) begin
          state_nxt = S_FIN;
        end else begin
          next_nxt   = ring_inc(node_idx);
          flag_raddr = ring_inc(node_idx);
          state_nxt  = S_WALK;
        end
      end
      S_WALK: begin
        if (flag_rdata) begin
          view_we    = 1'b1;
          view_wdata = rfd_pkg::VIEW_FAULTY;
          emit       = (cnt_r < rfd_pkg::SUSP_MAX);
          adv        = !emit || slot_free;
          if (emit && slot_free) begin
            out_valid_nxt   = 1'b1;
            out_tester_nxt  = node_r;
            out_tested_nxt  = rfd_pkg::NODE_W'(next_r);
            out_verdict_nxt = rfd_pkg::VERD_SUSPECT;
            out_last_nxt    = 1'b0;
            cnt_nxt         = cnt_r + rfd_pkg::CNT_W'(1);
          end
          if (adv) begin
            next_nxt   = ring_inc(next_r);
            flag_raddr = ring_inc(next_r);
          end
        end else begin
          fin_tested_nxt = rfd_pkg::NODE_W'(next_r);
          if (next_r == node_idx) begin
            fin_verdict_nxt = rfd_pkg::VERD_ALL_SUSPECT;
          end else begin
            view_we         = 1'b1;
            view_wdata      = rfd_pkg::VIEW_CORRECT;
            fin_verdict_nxt = rfd_pkg::VERD_CORRECT;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_tester_nxt  = node_r;
          out_tested_nxt  = fin_tested_r;
          out_verdict_nxt = fin_verdict_r;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_row_r   <= '0;
      clr_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      clr_col_r   <= clr_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r        <= node_nxt;
    next_r        <= next_nxt;
    cnt_r         <= cnt_nxt;
    fin_tested_r  <= fin_tested_nxt;
    fin_verdict_r <= fin_verdict_nxt;
    out_tester_r  <= out_tester_nxt;
    out_tested_r  <= out_tested_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_last_r    <= out_last_nxt;
  end

`ifndef SYNTHESIS
  // The diagonal of the view matrix is only ever written by the clearing pass.
  a_diag_correct: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> view_rdata == rfd_pkg::VIEW_CORRECT)
    else $error("view matrix diagonal entry is not correct during a walk");

  // A walk that returns to the tester must find the tester working.
  a_tester_working: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && next_r == node_idx) |-> !flag_rdata)
    else $error("walk reached a failed tester");

  // Leaving the final state always leaves a final result in the output register.
  a_final_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && $past(state_r == S_FIN)) |-> (out_valid_r && out_last_r))
    else $error("event finished without a final result");

  // Flags change only in the clearing pass or on the transfer of an event.
  a_flag_write: assert property (@(posedge clk) disable iff (!rst_n)
    flag_we |-> (state_r == S_CLEAR || (state_r == S_IDLE && in_xfer)))
    else $error("unexpected write to the failed flags");
`endif

endmodule
